FILE: hdl/double_ended_queue_core_assert.svh
// Assertion macros used by the deque checker file.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/deq_pkg.sv
// Package: shared types, codes and controller/datapath handshake structs for the deque.
`default_nettype none

package deq_pkg;

   localparam int DATA_W        = 32;
   localparam int OPC_W         = 3;
   localparam int STS_W         = 2;
   localparam int OCC_W         = 5;
   localparam int DEFAULT_DEPTH = 16;

   typedef logic [OPC_W-1:0]         opcode_type;
   typedef logic [STS_W-1:0]         status_type;
   typedef logic signed [DATA_W-1:0] data_type;

   localparam opcode_type OP_PUSH_FRONT = 3'd0;
   localparam opcode_type OP_PUSH_BACK  = 3'd1;
   localparam opcode_type OP_POP_FRONT  = 3'd2;
   localparam opcode_type OP_POP_BACK   = 3'd3;
   localparam opcode_type OP_FIND       = 3'd4;
   localparam opcode_type OP_CLEAR      = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // latch the incoming request
      logic exec;     // carry out the latched command
      logic fetch;    // load the refill word into front or back
      logic find;     // compare one entry of a search
      logic finish;   // load the result register
   } deq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type op;
      logic       empty;
      logic       multi;     // more than one element held
      logic       hit;
      logic       last;
      logic       rsp_free;
   } deq_stat_type;

endpackage

`default_nettype wire

FILE: hdl/deq_intf.sv
// Interfaces: request and result channels of the deque.
`default_nettype none

interface deq_req_if import deq_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   data_type   data_in;

   modport source (output valid, output opcode, output data_in, input ready);
   modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
   logic             valid;
   logic             ready;
   status_type       status;
   data_type         popped_value;
   logic             found;
   logic [OCC_W-1:0] occupancy;
   data_type         front_value;
   data_type         back_value;

   modport source (output valid, output status, output popped_value, output found,
                   output occupancy, output front_value, output back_value, input ready);
   modport sink   (input valid, input status, input popped_value, input found,
                   input occupancy, input front_value, input back_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/double_ended_queue_core.sv
// Top level: bounded double-ended queue over a ring store.
//
//   Channel   Dir  Handshake        Payload
//   req_chan  in   valid / ready    opcode, data_in
//   rsp_chan  out  valid / ready    status, popped_value, found, occupancy,
//                                   front_value, back_value
//
// Push, clear, a pop that empties the queue and any error go from execute straight to result load.
// A pop that leaves one or more words adds a refill step: one extra store read refills the end word.
// Find adds a search step per entry compared (one per cycle on the store read port).
// Reset clears head, count, controller and result valid; the store needs no clearing pass.
// A waiting result stays in the output register; the next request is still taken and
// worked up to its result load, which waits until the output register frees.
`default_nettype none

module double_ended_queue_core import deq_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);

   deq_cmd_type  cmd;
   deq_stat_type stat;

   // sequence each request through execute, refill or search, then result load
   deq_ctrl u_deq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the store, pointers, cached end words and the result register
   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_deq_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_chan.opcode),
      .req_data_in      (req_chan.data_in),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_popped_value (rsp_chan.popped_value),
      .rsp_found        (rsp_chan.found),
      .rsp_occupancy    (rsp_chan.occupancy),
      .rsp_front_value  (rsp_chan.front_value),
      .rsp_back_value   (rsp_chan.back_value)
   );

endmodule

`default_nettype wire

FILE: hdl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/deq_ctrl.sv
// Controller: sequences accept, execute, refill, search and result load.
`default_nettype none

module deq_ctrl import deq_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire deq_stat_type stat,
   output deq_cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_FIND,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // take nothing while reset is high
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            case (stat.op)
               OP_POP_FRONT, OP_POP_BACK: begin
                  state_in = stat.multi ? S_FETCH : S_DONE;
               end
               OP_FIND: begin
                  state_in = stat.empty ? S_DONE : S_FIND;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_DONE;
         end
         S_FIND: begin
            cmd.find = 1'b1;
            if (stat.hit || stat.last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // overlap the next accept with the result load
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.accept = 1'b1;
                  state_in   = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/deq_datapath.sv
// Datapath: ring store, head/count pointers, end words and result register.
`default_nettype none

module deq_datapath import deq_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire deq_cmd_type      cmd,
   output deq_stat_type          stat,
   input  wire opcode_type       req_opcode,
   input  wire data_type         req_data_in,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output status_type            rsp_status,
   output data_type              rsp_popped_value,
   output logic                  rsp_found,
   output logic [OCC_W-1:0]      rsp_occupancy,
   output data_type              rsp_front_value,
   output data_type              rsp_back_value
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   // fold a sum below twice the depth back into a slot
   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
      return (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
   endfunction

   opcode_type       cmd_op_ff, cmd_op_in;
   data_type         cmd_data_ff, cmd_data_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   data_type         front_ff, front_in;
   data_type         back_ff, back_in;
   status_type       status_ff, status_in;
   data_type         popped_ff, popped_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   data_type         rsp_popped_ff, rsp_popped_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [OCC_W-1:0] rsp_occ_ff, rsp_occ_in;
   data_type         rsp_front_ff, rsp_front_in;
   data_type         rsp_back_ff, rsp_back_in;

   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   data_type         ram_rd_data;

   logic [SW-1:0]    head_s, count_s, idx_s;
   logic [AW-1:0]    head_dec, head_inc, tail_slot, back_prev_slot, find_next;
   logic             is_empty, is_full, is_multi, hit, last;

   assign head_s   = SW'(head_ff);
   assign count_s  = SW'(count_ff);
   assign idx_s    = SW'(idx_ff);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == DEPTH_C);
   assign is_multi = (count_ff > CW'(1));

   assign head_dec       = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign head_inc       = wrap(head_s + SW'(1));
   assign tail_slot      = wrap(head_s + count_s);
   assign back_prev_slot = wrap(head_s + count_s - SW'(2));
   assign find_next      = wrap(head_s + idx_s + SW'(1));

   assign hit  = (ram_rd_data == cmd_data_ff);
   assign last = ((idx_ff + CW'(1)) == count_ff);

   assign stat.op       = cmd_op_ff;
   assign stat.empty    = is_empty;
   assign stat.multi    = is_multi;
   assign stat.hit      = hit;
   assign stat.last     = last;
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_deq_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cmd_data_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // store port steering
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = head_dec;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      if (cmd.exec) begin
         case (cmd_op_ff)
            OP_PUSH_FRONT: begin
               ram_wr_en   = !is_full;
               ram_wr_addr = head_dec;
            end
            OP_PUSH_BACK: begin
               ram_wr_en   = !is_full;
               ram_wr_addr = tail_slot;
            end
            OP_POP_FRONT: begin
               ram_rd_en   = is_multi;
               ram_rd_addr = head_inc;
            end
            OP_POP_BACK: begin
               ram_rd_en   = is_multi;
               ram_rd_addr = back_prev_slot;
            end
            OP_FIND: begin
               ram_rd_en   = !is_empty;
               ram_rd_addr = head_ff;
            end
            default: begin
            end
         endcase
      end else if (cmd.find) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = find_next;
      end
   end

   always_comb begin
      cmd_op_in     = cmd_op_ff;
      cmd_data_in   = cmd_data_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;

      if (cmd.accept) begin
         cmd_op_in   = req_opcode;
         cmd_data_in = req_data_in;
      end

      if (cmd.exec) begin
         status_in = ST_OK;
         popped_in = '0;
         found_in  = 1'b0;
         idx_in    = '0;
         case (cmd_op_ff)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
                  front_in = cmd_data_ff;
                  if (is_empty) begin
                     back_in = cmd_data_ff;
                  end
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  back_in  = cmd_data_ff;
                  if (is_empty) begin
                     front_in = cmd_data_ff;
                  end
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  popped_in = front_ff;
                  head_in   = head_inc;
                  count_in  = count_ff - CW'(1);
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  popped_in = back_ff;
                  count_in  = count_ff - CW'(1);
               end
            end
            OP_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.fetch) begin
         if (cmd_op_ff == OP_POP_FRONT) begin
            front_in = ram_rd_data;
         end else begin
            back_in = ram_rd_data;
         end
      end

      if (cmd.find) begin
         found_in = hit;
         idx_in   = idx_ff + CW'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_popped_in = popped_ff;
         rsp_found_in  = found_ff;
         rsp_occ_in    = OCC_W'(count_ff);
         rsp_front_in  = is_empty ? '0 : front_ff;
         rsp_back_in   = is_empty ? '0 : back_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_op_ff     <= cmd_op_in;
      cmd_data_ff   <= cmd_data_in;
      idx_ff        <= idx_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_back_value   = rsp_back_ff;

endmodule

`default_nettype wire

FILE: hdl/deq_checker.sv
// Checker: port-level assertions on the deque result channel, bound to the top level.
`default_nettype none
`include "double_ended_queue_core_assert.svh"

module deq_checker import deq_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire status_type       rsp_status,
   input wire data_type         rsp_popped_value,
   input wire logic             rsp_found,
   input wire logic [OCC_W-1:0] rsp_occupancy,
   input wire data_type         rsp_front_value,
   input wire data_type         rsp_back_value
);

   `DEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_popped_value) && $stable(rsp_occupancy), "result dropped or changed while stalled")
   `DEQ_ASSERT_IMPLY(a_err_clean, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_popped_value == '0 && !rsp_found, "error result carries a value or a hit")
   `DEQ_ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid && rsp_found, rsp_status == ST_OK && rsp_popped_value == '0, "search hit with bad status or popped word")
   `DEQ_ASSERT_IMPLY(a_empty_ends, clock, reset, rsp_valid && DEPTH < 32 && rsp_occupancy == '0, rsp_front_value == '0 && rsp_back_value == '0, "empty queue reports end words")
   `DEQ_ASSERT_IMPLY(a_occ_range, clock, reset, rsp_valid && DEPTH < 32, rsp_occupancy <= DEPTH, "occupancy beyond depth")

endmodule

bind double_ended_queue_core deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_popped_value (rsp_chan.popped_value),
   .rsp_found        (rsp_chan.found),
   .rsp_occupancy    (rsp_chan.occupancy),
   .rsp_front_value  (rsp_chan.front_value),
   .rsp_back_value   (rsp_chan.back_value)
);

`default_nettype wire
